[rtl/c20sx_pkg.sv]
// Shared types, constants and helper functions for the ChaCha20 stream XOR engine.
// Used by every module of the block; depends on nothing else.
package c20sx_pkg;

    localparam int ITEM_BYTES          = 8;
    localparam int DOUBLE_ROUNDS_DEF   = 10;
    localparam int CNT_W               = 4;
    localparam int POS_W               = 6;
    localparam int CFG_IDX_W           = 3;

    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    localparam logic [CFG_IDX_W-1:0] REG_KEY01    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY23    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY45    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY67    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE_LO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE_HI = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_CTR = 3'd6;

    typedef logic [31:0] word_t;
    typedef logic [15:0][31:0] block_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_status_t;

    function automatic word_t rotl(input word_t v, input int s);
        rotl = (v << s) | (v >> (32 - s));
    endfunction

endpackage

[rtl/chacha20_stream_xor.sv]
// ChaCha20 (IETF, 96-bit nonce) stream XOR engine, 8 message bytes per transaction.
// An accepted item passes through the holding stage and the output register; an item
// that needs a fresh 64-byte block waits in the holding stage for the block core.
// Within a block, 1 item per cycle while the output is not stalled; the block core sets the pace over
// long messages, and a start item first reloads the counter in the holding stage.
// Reset (aresetn low, synchronous) clears all handshake and counter state and the config.
module chacha20_stream_xor import c20sx_pkg::*; #(
    parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration write channel.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    // Input stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [71:0]          s_tdata,  // data_in[63:0], valid_bytes[67:64], zero pad
    input  logic [0:0]           s_tuser,  // start_message[0]
    // Result stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [71:0]          m_tdata   // data_out[63:0], out_byte_count[67:64], zero pad
);
    // Configuration registers.
    logic [255:0] key_reg;
    logic [95:0]  nonce_reg;
    word_t        init_ctr_reg;

    // Message position state.
    word_t            counter_reg;
    logic [POS_W-1:0] pos_reg;
    logic             ks_ready_reg;
    block_t           ks_reg;

    // Holding stage: one accepted item waiting for keystream.
    logic             hold_valid_reg;
    logic             hold_start_reg;
    logic [63:0]      hold_data_reg;
    logic [CNT_W-1:0] hold_cnt_reg;

    // Output register.
    logic             out_valid_reg;
    logic [63:0]      out_data_reg;
    logic [CNT_W-1:0] out_cnt_reg;

    core_status_t core_st;
    block_t       core_block;
    logic         core_start;

    logic             accept_in, advance, out_free, need_ks;
    logic [CNT_W-1:0] in_cnt;
    logic [POS_W:0]   pos_sum;
    logic [63:0]      ks_bytes, xored, byte_mask;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg      <= '0;
            nonce_reg    <= '0;
            init_ctr_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_KEY01:    key_reg[63:0]    <= cfg_data;
                REG_KEY23:    key_reg[127:64]  <= cfg_data;
                REG_KEY45:    key_reg[191:128] <= cfg_data;
                REG_KEY67:    key_reg[255:192] <= cfg_data;
                REG_NONCE_LO: nonce_reg[63:0]  <= cfg_data;
                REG_NONCE_HI: nonce_reg[95:64] <= cfg_data[31:0];
                REG_INIT_CTR: init_ctr_reg     <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // A count above eight saturates to eight.
    assign in_cnt = (s_tdata[67:64] > CNT_W'(ITEM_BYTES)) ? CNT_W'(ITEM_BYTES)
                                                          : s_tdata[67:64];

    // A start item first reloads the counter while in the holding stage; after that the item
    // needs keystream only if it carries at least one byte.
    assign out_free   = !out_valid_reg || m_tready;
    assign need_ks    = (hold_cnt_reg != '0);
    assign advance    = hold_valid_reg && !hold_start_reg && (!need_ks || ks_ready_reg)
                        && out_free;
    assign core_start = hold_valid_reg && !hold_start_reg && need_ks && !ks_ready_reg
                        && !core_st.busy;
    assign s_tready   = !hold_valid_reg || advance;
    assign accept_in  = s_tvalid && s_tready;

    c20sx_core #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_core (
        .aclk(aclk),
        .aresetn(aresetn),
        .start(core_start),
        .key(key_reg),
        .nonce(nonce_reg),
        .counter(counter_reg),
        .status(core_st),
        .block_out(core_block)
    );

    // Items always start on an 8-byte boundary of the block, so the keystream for one
    // item is one aligned 64-bit slice.
    assign ks_bytes = ks_reg[2*pos_reg[POS_W-1:3] +: 2];
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            byte_mask[8*b +: 8] = (CNT_W'(b) < hold_cnt_reg) ? 8'hFF : 8'h00;
        end
    end
    assign xored   = (hold_data_reg ^ ks_bytes) & byte_mask;
    assign pos_sum = {1'b0, pos_reg} + (POS_W+1)'(hold_cnt_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            hold_start_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            counter_reg    <= '0;
            pos_reg        <= '0;
            ks_ready_reg   <= 1'b0;
        end else begin
            if (accept_in) begin
                hold_valid_reg <= 1'b1;
                hold_start_reg <= s_tuser[0];
            end else if (advance) begin
                hold_valid_reg <= 1'b0;
            end else if (hold_valid_reg && hold_start_reg) begin
                hold_start_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            if (core_st.done) begin
                ks_ready_reg <= 1'b1;
            end

            if (hold_valid_reg && hold_start_reg) begin
                counter_reg  <= init_ctr_reg;
                pos_reg      <= '0;
                ks_ready_reg <= 1'b0;
            end else if (advance) begin
                // A full block moves to the next counter; a short item ends the message
                // and drops the rest of a partly used block.
                priority if (pos_sum[POS_W]) begin
                    counter_reg  <= counter_reg + 1'b1;
                    pos_reg      <= '0;
                    ks_ready_reg <= 1'b0;
                end else if (hold_cnt_reg != CNT_W'(ITEM_BYTES)) begin
                    if (pos_sum != '0) begin
                        counter_reg <= counter_reg + 1'b1;
                    end
                    pos_reg      <= '0;
                    ks_ready_reg <= 1'b0;
                end else begin
                    pos_reg <= pos_sum[POS_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept_in) begin
            hold_data_reg <= s_tdata[63:0];
            hold_cnt_reg  <= in_cnt;
        end
        if (advance) begin
            out_data_reg <= xored;
            out_cnt_reg  <= hold_cnt_reg;
        end
        if (core_st.done) begin
            ks_reg <= core_block;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_cnt_reg, out_data_reg};
endmodule

[rtl/c20sx_qr.sv]
// One half of a ChaCha quarter round (two add-xor-rotate steps).
// Depends on c20sx_pkg for the word type and rotate helper.
module c20sx_qr import c20sx_pkg::*; (
    input  logic  second_half,
    input  word_t a_in,
    input  word_t b_in,
    input  word_t c_in,
    input  word_t d_in,
    output word_t a_out,
    output word_t b_out,
    output word_t c_out,
    output word_t d_out
);
    word_t a1, dx, d1, c1, bx, b1;

    always_comb begin
        a1 = a_in + b_in;
        dx = d_in ^ a1;
        d1 = second_half ? rotl(dx, 8) : rotl(dx, 16);
        c1 = c_in + d1;
        bx = b_in ^ c1;
        b1 = second_half ? rotl(bx, 7) : rotl(bx, 12);
    end

    assign a_out = a1;
    assign b_out = b1;
    assign c_out = c1;
    assign d_out = d1;
endmodule

[rtl/c20sx_core.sv]
// ChaCha block function: four quarter-round lanes work on the state side by side,
// half a round per cycle, and a final add merges the result with the initial state.
// Depends on c20sx_pkg and c20sx_qr.
module c20sx_core import c20sx_pkg::*; #(
    parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [255:0] key,
    input  logic [95:0]  nonce,
    input  word_t        counter,
    output core_status_t status,
    output block_t       block_out
);
    localparam int STEPS  = 4 * DOUBLE_ROUNDS;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

    block_t w_reg, w_next, init_reg, init_val;
    logic [STEP_W-1:0] step_reg;
    logic busy_reg, done_reg;
    logic diag, second_half;

    word_t      la [4], lb [4], lc [4], ld [4];
    word_t      oa [4], ob [4], oc [4], od [4];
    logic [3:0] ia [4], ib [4], ic [4], id [4];

    assign second_half = step_reg[0];
    assign diag        = (STEP_W > 1) ? step_reg[STEP_W > 1 ? 1 : 0] : 1'b0;

    always_comb begin
        init_val[0]  = SIGMA0;
        init_val[1]  = SIGMA1;
        init_val[2]  = SIGMA2;
        init_val[3]  = SIGMA3;
        for (int k = 0; k < 8; k++) begin
            init_val[4 + k] = key[32*k +: 32];
        end
        init_val[12] = counter;
        init_val[13] = nonce[31:0];
        init_val[14] = nonce[63:32];
        init_val[15] = nonce[95:64];
    end

    // Column rounds use lane i on words i, 4+i, 8+i, 12+i; diagonal rounds shift
    // the b, c and d rows by one, two and three places.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            ia[i] = {2'd0, 2'(i)};
            ib[i] = {2'd1, 2'(i) + (diag ? 2'd1 : 2'd0)};
            ic[i] = {2'd2, 2'(i) + (diag ? 2'd2 : 2'd0)};
            id[i] = {2'd3, 2'(i) + (diag ? 2'd3 : 2'd0)};
            la[i] = w_reg[ia[i]];
            lb[i] = w_reg[ib[i]];
            lc[i] = w_reg[ic[i]];
            ld[i] = w_reg[id[i]];
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_lane
        c20sx_qr u_qr (
            .second_half(second_half),
            .a_in(la[g]), .b_in(lb[g]), .c_in(lc[g]), .d_in(ld[g]),
            .a_out(oa[g]), .b_out(ob[g]), .c_out(oc[g]), .d_out(od[g])
        );
    end

    always_comb begin
        w_next = w_reg;
        for (int i = 0; i < 4; i++) begin
            w_next[ia[i]] = oa[i];
            w_next[ib[i]] = ob[i];
            w_next[ic[i]] = oc[i];
            w_next[id[i]] = od[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg && !done_reg) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg && !done_reg) begin
            w_reg    <= init_val;
            init_reg <= init_val;
        end else if (busy_reg) begin
            w_reg <= w_next;
        end
    end

    always_comb begin
        for (int k = 0; k < 16; k++) begin
            block_out[k] = w_reg[k] + init_reg[k];
        end
    end

    assign status.busy = busy_reg | done_reg;
    assign status.done = done_reg;
endmodule

[rtl/c20sx_check.sv]
// Port-level checker for the ChaCha20 stream XOR engine, bound to the top level.
// Depends on c20sx_pkg for the register index width.
module c20sx_check import c20sx_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [63:0]          cfg_data,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [71:0]          s_tdata,
    input logic [0:0]           s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [71:0]          m_tdata
);
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[67:64] <= 4'd8 && m_tdata[71:68] == 4'd0)
        else $error("result byte count out of range");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[67:64] == 4'd0 |-> m_tdata[63:0] == 64'd0)
        else $error("empty result carries data");

    a_short_top: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[67:64] != 4'd8 |-> m_tdata[63:56] == 8'd0)
        else $error("short result has a nonzero top byte");
endmodule

bind chacha20_stream_xor c20sx_check u_check (.*);
